// File: sv/hhc_pkg.sv
// ----------------------------------------------------------------------------
// hhc_pkg
// shared codes, widths and helpers of the humidistat hysteresis controller
// ----------------------------------------------------------------------------
package hhc_pkg;

	localparam int EMA_ALPHA_Q8_DEF = 77;
	localparam logic [14:0] RH_MAX = 15'd25600;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_MANUAL = 3'd1;
	localparam logic [2:0] OP_AUTO   = 3'd2;
	localparam logic [2:0] OP_STATUS = 3'd3;
	localparam logic [2:0] OP_START  = 3'd4;

	localparam logic [3:0] R_DRY     = 4'd0;
	localparam logic [3:0] R_WET     = 4'd1;
	localparam logic [3:0] R_BAND    = 4'd2;
	localparam logic [3:0] R_DWELL   = 4'd3;
	localparam logic [3:0] R_MANUAL  = 4'd4;
	localparam logic [3:0] R_MAXRUN  = 4'd5;
	localparam logic [3:0] R_LOCKOUT = 4'd6;
	localparam logic [3:0] R_LOST    = 4'd7;
	localparam logic [3:0] R_NOCODE  = 4'd8;
	localparam logic [3:0] R_BOOT    = 4'd9;

	localparam logic [2:0] REG_ON_BELOW  = 3'd0;
	localparam logic [2:0] REG_OFF_ABOVE = 3'd1;
	localparam logic [2:0] REG_MAX_RUN   = 3'd2;
	localparam logic [2:0] REG_OVR_HOLD  = 3'd3;
	localparam logic [2:0] REG_STALE     = 3'd4;
	localparam logic [2:0] REG_LOCKOUT   = 3'd5;
	localparam logic [2:0] REG_DWELL     = 3'd6;
	localparam logic [2:0] REG_RETRY     = 3'd7;

	// status that rides along the output pipeline
	typedef struct packed {
		logic        unit_on;
		logic        overriding;
		logic [3:0]  reason;
		logic [14:0] rh;
		logic        rh_valid;
		logic        lockout;
		logic        tx_req;
		logic        tx_level;
	} status_t;

	// seconds to milliseconds, shift and subtract
	function automatic logic [29:0] scale_1k(input logic [19:0] v);
		logic [29:0] w;
		w = {10'd0, v};
		return (w << 10) - (w << 4) - (w << 3);
	endfunction

	// positive part of a wrap-safe signed difference
	function automatic logic [30:0] pos_diff(input logic [31:0] now, input logic [31:0] since);
		logic [31:0] d;
		d = now - since;
		return d[31] ? 31'd0 : d[30:0];
	endfunction

endpackage

// File: sv/humidistat_hysteresis_controller_core.sv
// ----------------------------------------------------------------------------
// humidistat_hysteresis_controller_core
// on/off humidistat with ema filter, priority rules and status timers
// ----------------------------------------------------------------------------
// path: an accepted beat passes the s1, s2 and output registers to its result beat
// throughput: one beat per cycle while out_stall does not back up the pipe; decision
//   and state update finish in the accept cycle, seconds division runs in the output pipe
// reset: arst_n clears state and loads register defaults; no clearing pass
// ----------------------------------------------------------------------------
module humidistat_hysteresis_controller_core #(
	parameter int EMA_ALPHA_Q8 = hhc_pkg::EMA_ALPHA_Q8_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] now_ms,
	input  logic        sample_valid,
	input  logic [14:0] rh_sample,
	input  logic        manual_on,
	input  logic        transmit_ok,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        unit_on,
	output logic        overriding,
	output logic [3:0]  reason_code,
	output logic [14:0] smoothed_rh,
	output logic        smoothed_valid,
	output logic [21:0] state_age_sec,
	output logic [19:0] override_left_sec,
	output logic [19:0] dwell_left_sec,
	output logic [19:0] lockout_left_sec,
	output logic        transmit_request,
	output logic        transmit_level
);
	import hhc_pkg::*;

	localparam logic [8:0] ALPHA = 9'(EMA_ALPHA_Q8);
	localparam logic [8:0] BETA  = 9'(256 - EMA_ALPHA_Q8);

	// configuration, with millisecond copies for compares
	logic [14:0] on_below_q, off_above_q;
	logic [19:0] hold_q, lock_q, dwell_q;
	logic [29:0] maxrun_k_q, hold_k_q, stale_k_q, lock_k_q, dwell_k_q, retry_k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_below_q  <= 15'd10240;
			off_above_q <= 15'd14080;
			hold_q      <= 20'd3600;
			lock_q      <= 20'd1800;
			dwell_q     <= 20'd300;
			maxrun_k_q  <= 30'd14400000;
			hold_k_q    <= 30'd3600000;
			stale_k_q   <= 30'd60000;
			lock_k_q    <= 30'd1800000;
			dwell_k_q   <= 30'd300000;
			retry_k_q   <= 30'd60000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ON_BELOW:  on_below_q <= cfg_data[14:0];
				REG_OFF_ABOVE: off_above_q <= cfg_data[14:0];
				REG_MAX_RUN:   maxrun_k_q <= scale_1k(cfg_data);
				REG_OVR_HOLD: begin
					hold_q   <= cfg_data;
					hold_k_q <= scale_1k(cfg_data);
				end
				REG_STALE:     stale_k_q <= scale_1k(cfg_data);
				REG_LOCKOUT: begin
					lock_q   <= cfg_data;
					lock_k_q <= scale_1k(cfg_data);
				end
				REG_DWELL: begin
					dwell_q   <= cfg_data;
					dwell_k_q <= scale_1k(cfg_data);
				end
				REG_RETRY:     retry_k_q <= scale_1k(cfg_data);
				default: ;
			endcase
		end
	end

	// controller state
	logic        on_q, fv_q, good_q, ovr_q, lk_q;
	logic [3:0]  reason_q;
	logic [14:0] filt_q;
	logic [31:0] lg_t_q, sw_t_q, att_t_q, run_t_q, ovr_t_q, lk_t_q;

	logic        n_on, n_fv, n_good, n_ovr, n_lk;
	logic [3:0]  n_reason;
	logic [14:0] n_filt;
	logic [31:0] n_lg_t, n_sw_t, n_att_t, n_run_t, n_ovr_t, n_lk_t;
	logic        tx_req, tx_lvl;

	logic        accept;
	logic [14:0] rh_sat;
	logic [24:0] ema_sum;
	logic        run_dec, ap, ap_want, want;
	logic [3:0]  ap_why, why;
	logic        ovr_live;

	assign accept  = in_valid && !in_stall;
	assign rh_sat  = (rh_sample > RH_MAX) ? RH_MAX : rh_sample;
	assign ema_sum = {10'd0, rh_sat} * {16'd0, ALPHA} + {10'd0, filt_q} * {16'd0, BETA}
		+ 25'd128;

	always_comb begin
		n_on = on_q; n_fv = fv_q; n_good = good_q; n_ovr = ovr_q; n_lk = lk_q;
		n_reason = reason_q; n_filt = filt_q;
		n_lg_t = lg_t_q; n_sw_t = sw_t_q; n_att_t = att_t_q; n_run_t = run_t_q;
		n_ovr_t = ovr_t_q; n_lk_t = lk_t_q;
		run_dec = 1'b0; ap = 1'b0; ap_want = 1'b0; ap_why = R_BAND;
		want = on_q; why = R_BAND; ovr_live = 1'b0;

		case (op)
			OP_TICK: begin
				if (sample_valid) begin
					n_filt = fv_q ? ema_sum[22:8] : rh_sat;
					n_fv   = 1'b1;
					n_good = 1'b1;
					n_lg_t = now_ms;
				end
				run_dec = 1'b1;
			end
			OP_MANUAL: begin
				n_lk    = 1'b0;
				n_ovr   = 1'b1;
				n_ovr_t = now_ms;
				if (manual_on == on_q) begin
					n_reason = R_MANUAL;
				end else begin
					ap = 1'b1; ap_want = manual_on; ap_why = R_MANUAL;
				end
			end
			OP_AUTO: begin
				n_ovr   = 1'b0;
				run_dec = 1'b1;
			end
			OP_START: begin
				n_on     = manual_on;
				n_reason = R_BOOT;
				n_sw_t   = now_ms;
				n_att_t  = now_ms;
				n_run_t  = now_ms;
			end
			default: ;
		endcase

		if (run_dec) begin
			ovr_live = n_ovr && pos_diff(now_ms, ovr_t_q) < {1'b0, hold_k_q};
			if (on_q && pos_diff(now_ms, run_t_q) >= {1'b0, maxrun_k_q}) begin
				n_ovr  = 1'b0;
				ap = 1'b1; ap_want = 1'b0; ap_why = R_MAXRUN;
				n_lk   = 1'b1;
				n_lk_t = now_ms;
			end else if (ovr_live) begin
				n_reason = R_MANUAL;
			end else begin
				n_ovr = 1'b0;
				if (!(n_fv && n_good && pos_diff(now_ms, n_lg_t) < {1'b0, stale_k_q})) begin
					if (on_q) begin
						ap = 1'b1; ap_want = 1'b0; ap_why = R_LOST;
					end else begin
						n_reason = R_LOST;
					end
				end else if (lk_q && pos_diff(now_ms, lk_t_q) < {1'b0, lock_k_q}) begin
					if (on_q) begin
						ap = 1'b1; ap_want = 1'b0; ap_why = R_LOCKOUT;
					end else begin
						n_reason = R_LOCKOUT;
					end
				end else begin
					n_lk = 1'b0;
					if (n_filt < on_below_q) begin
						want = 1'b1; why = R_DRY;
					end else if (n_filt > off_above_q) begin
						want = 1'b0; why = R_WET;
					end
					if (want == on_q) begin
						n_reason = why;
					end else if (!want && pos_diff(now_ms, sw_t_q) < {1'b0, dwell_k_q}) begin
						n_reason = R_DWELL;
					end else if (!(reason_q == R_NOCODE &&
						pos_diff(now_ms, att_t_q) < {1'b0, retry_k_q})) begin
						ap = 1'b1; ap_want = want; ap_why = why;
					end
				end
			end
		end

		// transmit attempt
		tx_req = ap;
		tx_lvl = ap && ap_want;
		if (ap) begin
			n_att_t = now_ms;
			if (!transmit_ok) begin
				n_reason = R_NOCODE;
			end else begin
				n_on     = ap_want;
				n_reason = ap_why;
				n_sw_t   = now_ms;
				if (ap_want) begin
					n_run_t = now_ms;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q <= 1'b0; fv_q <= 1'b0; good_q <= 1'b0; ovr_q <= 1'b0; lk_q <= 1'b0;
			reason_q <= R_BOOT; filt_q <= 15'd0;
			lg_t_q <= 32'd0; sw_t_q <= 32'd0; att_t_q <= 32'd0; run_t_q <= 32'd0;
			ovr_t_q <= 32'd0; lk_t_q <= 32'd0;
		end else if (accept) begin
			on_q <= n_on; fv_q <= n_fv; good_q <= n_good; ovr_q <= n_ovr; lk_q <= n_lk;
			reason_q <= n_reason; filt_q <= n_filt;
			lg_t_q <= n_lg_t; sw_t_q <= n_sw_t; att_t_q <= n_att_t; run_t_q <= n_run_t;
			ovr_t_q <= n_ovr_t; lk_t_q <= n_lk_t;
		end
	end

	// output pipe: differences, then seconds, then remaining times
	logic        v_s1, v_s2, v_q;
	logic        rdy_o, rdy_s2, rdy_s1;
	status_t     st_s1, st_s2;
	logic [30:0] d_sw_s1, d_ovr_s1, d_lk_s1;
	logic [21:0] age_s2, ovr_used_s2, lk_used_s2;

	assign rdy_o    = !v_q || !out_stall;
	assign rdy_s2   = !v_s2 || rdy_o;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_o)  v_q  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1    <= '{unit_on: n_on, overriding: n_ovr, reason: n_reason, rh: n_filt,
				rh_valid: n_fv, lockout: n_lk, tx_req: tx_req, tx_level: tx_lvl};
			d_sw_s1  <= pos_diff(now_ms, n_sw_t);
			d_ovr_s1 <= pos_diff(now_ms, n_ovr_t);
			d_lk_s1  <= pos_diff(now_ms, n_lk_t);
		end
		if (rdy_s2 && v_s1) begin
			st_s2 <= st_s1;
		end
	end

	hhc_sec_div u_div_age (.clk(clk), .en(rdy_s2 && v_s1), .ms(d_sw_s1),  .sec_s2(age_s2));
	hhc_sec_div u_div_ovr (.clk(clk), .en(rdy_s2 && v_s1), .ms(d_ovr_s1), .sec_s2(ovr_used_s2));
	hhc_sec_div u_div_lk  (.clk(clk), .en(rdy_s2 && v_s1), .ms(d_lk_s1),  .sec_s2(lk_used_s2));

	always_ff @(posedge clk) begin
		if (rdy_o && v_s2) begin
			unit_on          <= st_s2.unit_on;
			overriding       <= st_s2.overriding;
			reason_code      <= st_s2.reason;
			smoothed_rh      <= st_s2.rh;
			smoothed_valid   <= st_s2.rh_valid;
			transmit_request <= st_s2.tx_req;
			transmit_level   <= st_s2.tx_level;
			state_age_sec    <= age_s2;
			override_left_sec <= (st_s2.overriding && ovr_used_s2 < {2'd0, hold_q})
				? hold_q - ovr_used_s2[19:0] : 20'd0;
			dwell_left_sec   <= (age_s2 < {2'd0, dwell_q}) ? dwell_q - age_s2[19:0] : 20'd0;
			lockout_left_sec <= (st_s2.lockout && lk_used_s2 < {2'd0, lock_q})
				? lock_q - lk_used_s2[19:0] : 20'd0;
		end
	end

	assign out_valid = v_q;

	// override and lockout exclude each other
	a_ovr_lk_excl: assert property (@(posedge clk) disable iff (!arst_n) !(ovr_q && lk_q))
		else $error("override and lockout both active");

	// a level without a request means the attempt flag went astray
	a_tx_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!transmit_level || transmit_request))
		else $error("transmit level without request");

	// a held first stage keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy_s2) |=> (v_s1 && $stable(d_sw_s1)))
		else $error("stage one beat lost while held");

	// an empty pipe never pushes back
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("stall with empty first stage");

endmodule

// File: sv/hhc_sec_div.sv
// ----------------------------------------------------------------------------
// hhc_sec_div
// registered milliseconds to whole seconds, by reciprocal multiply
// ----------------------------------------------------------------------------
module hhc_sec_div (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] ms,
	output logic [21:0] sec_s2
);
	// ms/1000 = (ms>>3)/125, exact for 28-bit operands with 2^35 scaling
	localparam logic [28:0] RECIP_125 = 29'd274877907;

	logic [56:0] prod;

	assign prod = {29'd0, ms[30:3]} * {28'd0, RECIP_125};

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s2 <= prod[56:35];
		end
	end

endmodule
